// ===== hw/rtl/cemap_pkg.sv =====
// cemap_pkg: shared types, widths, codes and the arctangent table of the
// cubemap to equirectangular sample address block. No dependencies.
`timescale 1ns / 1ps

package cemap_pkg;

   // field and register widths
   localparam int unsigned FACE_W   = 3;
   localparam int unsigned TEXEL_W  = 12;
   localparam int unsigned SIZE_W   = 13;
   localparam int unsigned WIDTH_W  = 14;
   localparam int unsigned HEIGHT_W = 13;
   localparam int unsigned SRC_X_W  = 13;
   localparam int unsigned SRC_Y_W  = 12;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 14;

   // internal datapath widths
   localparam int unsigned QUO_W = 16;   // face-plane quotient bits
   localparam int unsigned DIR_W = 17;   // signed Q1.15 direction with room for +-1.0
   localparam int unsigned CRD_W = 28;   // cordic x/y
   localparam int unsigned ANG_W = 26;   // angle, 2^-24 turn units
   localparam int unsigned RAD_W = 32;   // x^2 + z^2
   localparam int unsigned ATAN_ENTRIES = 24;

   // parameter defaults
   localparam int unsigned MAX_CUBE_SIZE_DEF  = 4096;
   localparam int unsigned MAX_EQUI_WIDTH_DEF = 8192;
   localparam int unsigned CORDIC_STAGES_DEF  = 16;
   localparam int unsigned EQUI_HEIGHT_CAP    = 4096;

   // register reset values
   localparam logic [SIZE_W-1:0]   CUBE_SIZE_RST   = 13'd512;
   localparam logic [WIDTH_W-1:0]  EQUI_WIDTH_RST  = 14'd2048;
   localparam logic [HEIGHT_W-1:0] EQUI_HEIGHT_RST = 13'd1024;

   // angle constants
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd4194304;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 26'sd8388608;
   localparam logic signed [DIR_W-1:0] ONE_Q15      = 17'sd32768;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CUBE_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EQUI_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EQUI_HEIGHT = 2'd2;

   // face codes
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic [FACE_W-1:0]  face;
      logic [TEXEL_W-1:0] texel_x;
      logic [TEXEL_W-1:0] texel_y;
   } req_type;

   typedef struct packed {
      logic [SRC_X_W-1:0] source_x;
      logic [SRC_Y_W-1:0] source_y;
      logic               bad_request;
   } rsp_type;

   // round(atan(2^-i) / (2*pi) * 2^24)
   function automatic logic [ANG_W-1:0] atan_turn(input int unsigned idx);
      logic [ANG_W-1:0] a;
      case (idx)
         0:  a = 26'd2097152;
         1:  a = 26'd1238021;
         2:  a = 26'd654136;
         3:  a = 26'd332050;
         4:  a = 26'd166669;
         5:  a = 26'd83416;
         6:  a = 26'd41718;
         7:  a = 26'd20860;
         8:  a = 26'd10430;
         9:  a = 26'd5215;
         10: a = 26'd2608;
         11: a = 26'd1304;
         12: a = 26'd652;
         13: a = 26'd326;
         14: a = 26'd163;
         15: a = 26'd81;
         16: a = 26'd41;
         17: a = 26'd20;
         18: a = 26'd10;
         19: a = 26'd5;
         20: a = 26'd3;
         21: a = 26'd1;
         22: a = 26'd1;
         default: a = 26'd0;
      endcase
      return a;
   endfunction

endpackage

// ===== hw/rtl/cemap_div_cell.sv =====
// cemap_div_cell: one restoring division step, one quotient bit per cell.
// Depends on cemap_pkg.
`timescale 1ns / 1ps

module cemap_div_cell #(
   parameter bit NUM_BIT = 1'b0
) (
   input  logic                            clock,
   input  logic                            adv,
   input  logic [cemap_pkg::SIZE_W-1:0]    size_in,
   input  logic [cemap_pkg::SIZE_W-1:0]    rem_in,
   input  logic [cemap_pkg::QUO_W-1:0]     quo_in,
   output logic [cemap_pkg::SIZE_W-1:0]    rem_out,
   output logic [cemap_pkg::QUO_W-1:0]     quo_out
);

   logic [cemap_pkg::SIZE_W:0]   trial;
   logic                         fits;
   logic [cemap_pkg::SIZE_W-1:0] rem_ff, rem_in_nx;
   logic [cemap_pkg::QUO_W-1:0]  quo_ff, quo_in_nx;

   // shift in the next numerator bit and try to subtract the divisor
   always_comb begin
      trial     = {rem_in, NUM_BIT};
      fits      = trial >= {1'b0, size_in};
      rem_in_nx = fits ? cemap_pkg::SIZE_W'(trial - {1'b0, size_in})
                       : cemap_pkg::SIZE_W'(trial);
      quo_in_nx = {quo_in[cemap_pkg::QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in_nx;
         quo_ff <= quo_in_nx;
      end
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

// ===== hw/rtl/cemap_sqrt_cell.sv =====
// cemap_sqrt_cell: one digit step of the integer floor square root.
// Depends on cemap_pkg.
`timescale 1ns / 1ps

module cemap_sqrt_cell #(
   parameter int unsigned BIT_POS = 0
) (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [cemap_pkg::RAD_W-1:0]  num_in,
   input  logic [cemap_pkg::RAD_W-1:0]  res_in,
   output logic [cemap_pkg::RAD_W-1:0]  num_out,
   output logic [cemap_pkg::RAD_W-1:0]  res_out
);

   localparam logic [cemap_pkg::RAD_W-1:0] BIT_VAL = cemap_pkg::RAD_W'(1) << BIT_POS;

   logic [cemap_pkg::RAD_W-1:0] trial;
   logic [cemap_pkg::RAD_W-1:0] num_ff, num_in_nx, res_ff, res_in_nx;

   // compare against res + bit, take the digit when it fits
   always_comb begin
      trial = res_in + BIT_VAL;
      if (num_in >= trial) begin
         num_in_nx = num_in - trial;
         res_in_nx = (res_in >> 1) + BIT_VAL;
      end else begin
         num_in_nx = num_in;
         res_in_nx = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in_nx;
         res_ff <= res_in_nx;
      end
   end

   assign num_out = num_ff;
   assign res_out = res_ff;

endmodule

// ===== hw/rtl/cemap_cordic_cell.sv =====
// cemap_cordic_cell: one vectoring rotation of the cordic chain.
// Depends on cemap_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module cemap_cordic_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [cemap_pkg::CRD_W-1:0]  x_in,
   input  logic signed [cemap_pkg::CRD_W-1:0]  y_in,
   input  logic signed [cemap_pkg::ANG_W-1:0]  z_in,
   output logic signed [cemap_pkg::CRD_W-1:0]  x_out,
   output logic signed [cemap_pkg::CRD_W-1:0]  y_out,
   output logic signed [cemap_pkg::ANG_W-1:0]  z_out
);

   localparam logic signed [cemap_pkg::ANG_W-1:0] ATAN =
      signed'(cemap_pkg::atan_turn(IDX));

   logic signed [cemap_pkg::CRD_W-1:0] xs, ys;
   logic                               y_pos;
   logic signed [cemap_pkg::CRD_W-1:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic signed [cemap_pkg::ANG_W-1:0] z_ff, z_in_nx;

   // rotate toward the x axis, arithmetic shifts round down
   always_comb begin
      xs    = x_in >>> IDX;
      ys    = y_in >>> IDX;
      y_pos = !y_in[cemap_pkg::CRD_W-1] && (y_in != '0);
      if (y_pos) begin
         x_in_nx = x_in + ys;
         y_in_nx = y_in - xs;
         z_in_nx = z_in + ATAN;
      end else begin
         x_in_nx = x_in - ys;
         y_in_nx = y_in + xs;
         z_in_nx = z_in - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in_nx;
         y_ff <= y_in_nx;
         z_ff <= z_in_nx;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

// ===== hw/rtl/cubemap_to_equirect_sample_address_top.sv =====
// cubemap_to_equirect_sample_address_top: texel to equirectangular source
// pixel address pipeline. Depends on cemap_pkg and the div, sqrt, cordic cells.
`timescale 1ns / 1ps

//  channel  | ports                              | moves
//  ---------+------------------------------------+-------------------------
//  request  | req_valid, req_ready, req_word     | face and texel, one word
//  response | rsp_valid, rsp_ready, rsp_word     | source pixel and flag
//  config   | csr_we, csr_index, csr_wdata       | register write, no wait
//
// One word enters per cycle unless the row stalls; the path runs through the
// 16 divider cells, 16 square root cells and the cordic cells in a row.
// Reset is synchronous and clears valid bits and restores register defaults.
// A response not taken stalls the whole row; the row holds its words.

module cubemap_to_equirect_sample_address_top #(
   parameter int unsigned MAX_CUBE_SIZE  = cemap_pkg::MAX_CUBE_SIZE_DEF,
   parameter int unsigned MAX_EQUI_WIDTH = cemap_pkg::MAX_EQUI_WIDTH_DEF,
   parameter int unsigned CORDIC_STAGES  = cemap_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cemap_pkg::req_type                  req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cemap_pkg::rsp_type                  rsp_word,
   input  logic                                csr_we,
   input  logic [cemap_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cemap_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned DIV_N  = cemap_pkg::QUO_W;
   localparam int unsigned SQRT_N = cemap_pkg::RAD_W / 2;
   localparam int unsigned CRD_N  = CORDIC_STAGES;
   localparam int unsigned DEPTH  = DIV_N + SQRT_N + CRD_N + 4;

   localparam int unsigned SW  = cemap_pkg::SIZE_W;
   localparam int unsigned WW  = cemap_pkg::WIDTH_W;
   localparam int unsigned HW  = cemap_pkg::HEIGHT_W;
   localparam int unsigned QW  = cemap_pkg::QUO_W;
   localparam int unsigned DW  = cemap_pkg::DIR_W;
   localparam int unsigned CW  = cemap_pkg::CRD_W;
   localparam int unsigned AW  = cemap_pkg::ANG_W;
   localparam int unsigned RW  = cemap_pkg::RAD_W;
   localparam int unsigned FW  = cemap_pkg::FACE_W;
   localparam int unsigned PXW = AW - 1 + WW;   // x product
   localparam int unsigned PYW = AW - 1 + HW;   // y product

   // config registers
   logic [SW-1:0] cube_size_ff;
   logic [WW-1:0] equi_width_ff;
   logic [HW-1:0] equi_height_ff;
   logic [SW-1:0] size_eff;
   logic [WW-1:0] width_eff;
   logic [HW-1:0] height_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cube_size_ff   <= cemap_pkg::CUBE_SIZE_RST;
         equi_width_ff  <= cemap_pkg::EQUI_WIDTH_RST;
         equi_height_ff <= cemap_pkg::EQUI_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            cemap_pkg::CSR_CUBE_SIZE:   cube_size_ff   <= csr_wdata[SW-1:0];
            cemap_pkg::CSR_EQUI_WIDTH:  equi_width_ff  <= csr_wdata[WW-1:0];
            cemap_pkg::CSR_EQUI_HEIGHT: equi_height_ff <= csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   // limits on the configured sizes
   always_comb begin
      size_eff   = (32'(cube_size_ff) > MAX_CUBE_SIZE) ? SW'(MAX_CUBE_SIZE) : cube_size_ff;
      width_eff  = (32'(equi_width_ff) > MAX_EQUI_WIDTH) ? WW'(MAX_EQUI_WIDTH)
                                                         : equi_width_ff;
      height_eff = (32'(equi_height_ff) > cemap_pkg::EQUI_HEIGHT_CAP)
                   ? HW'(cemap_pkg::EQUI_HEIGHT_CAP) : equi_height_ff;
   end

   // valid row and stall
   logic             valid_ff [DEPTH];
   logic             adv;

   assign adv       = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < DEPTH; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // entry stage: range check
   logic [FW-1:0]                 face_d_ff [DIV_N+1];
   logic                          bad_d_ff  [DIV_N+1];
   logic [cemap_pkg::TEXEL_W-1:0] tx_ff, ty_ff;
   logic                          bad_in;

   assign bad_in = (req_word.face > cemap_pkg::FACE_NEG_Z) || (size_eff == '0) ||
                   ({1'b0, req_word.texel_x} >= size_eff) ||
                   ({1'b0, req_word.texel_y} >= size_eff);

   always_ff @(posedge clock) begin
      if (adv) begin
         face_d_ff[0] <= req_word.face;
         bad_d_ff[0]  <= bad_in;
         tx_ff        <= req_word.texel_x;
         ty_ff        <= req_word.texel_y;
         for (int k = 0; k < DIV_N; k++) begin
            face_d_ff[k+1] <= face_d_ff[k];
            bad_d_ff[k+1]  <= bad_d_ff[k];
         end
      end
   end

   // divider row: (2c+1)*2^15 / size, numerator is c then a single one bit
   logic [SW-1:0] rem_u [DIV_N+1];
   logic [SW-1:0] rem_v [DIV_N+1];
   logic [QW-1:0] quo_u [DIV_N+1];
   logic [QW-1:0] quo_v [DIV_N+1];

   assign rem_u[0] = SW'(tx_ff);
   assign rem_v[0] = SW'(ty_ff);
   assign quo_u[0] = '0;
   assign quo_v[0] = '0;

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      cemap_div_cell #(.NUM_BIT(k == 0)) u_div_u (
         .clock(clock), .adv(adv), .size_in(size_eff),
         .rem_in(rem_u[k]), .quo_in(quo_u[k]),
         .rem_out(rem_u[k+1]), .quo_out(quo_u[k+1])
      );
      cemap_div_cell #(.NUM_BIT(k == 0)) u_div_v (
         .clock(clock), .adv(adv), .size_in(size_eff),
         .rem_in(rem_v[k]), .quo_in(quo_v[k]),
         .rem_out(rem_v[k+1]), .quo_out(quo_v[k+1])
      );
   end

   // direction stage: face vector, quadrant fold, squared radius
   logic signed [DW-1:0]   u_c, v_c, dx, dy, dz;
   logic signed [CW-1:0]   xx, yy, px0, py0;
   logic signed [AW-1:0]   pz0;
   logic signed [2*DW-1:0] sq_x, sq_z;
   logic [RW-1:0]          n_c;

   always_comb begin
      u_c = signed'({1'b0, quo_u[DIV_N]}) - cemap_pkg::ONE_Q15;
      v_c = signed'({1'b0, quo_v[DIV_N]}) - cemap_pkg::ONE_Q15;
      case (face_d_ff[DIV_N])
         cemap_pkg::FACE_POS_X: begin
            dx = cemap_pkg::ONE_Q15;  dy = -v_c; dz = -u_c;
         end
         cemap_pkg::FACE_NEG_X: begin
            dx = -cemap_pkg::ONE_Q15; dy = -v_c; dz = u_c;
         end
         cemap_pkg::FACE_POS_Y: begin
            dx = u_c; dy = cemap_pkg::ONE_Q15;  dz = v_c;
         end
         cemap_pkg::FACE_NEG_Y: begin
            dx = u_c; dy = -cemap_pkg::ONE_Q15; dz = -v_c;
         end
         cemap_pkg::FACE_POS_Z: begin
            dx = u_c; dy = -v_c; dz = cemap_pkg::ONE_Q15;
         end
         default: begin
            dx = -u_c; dy = -v_c; dz = -cemap_pkg::ONE_Q15;
         end
      endcase
      xx = {{(CW-DW){dx[DW-1]}}, dx} <<< 8;
      yy = {{(CW-DW){dz[DW-1]}}, dz} <<< 8;
      // fold the left half plane onto the right
      if (xx[CW-1]) begin
         if (!yy[CW-1]) begin
            px0 = yy;  py0 = -xx; pz0 = cemap_pkg::QUARTER_TURN;
         end else begin
            px0 = -yy; py0 = xx;  pz0 = -cemap_pkg::QUARTER_TURN;
         end
      end else begin
         px0 = xx; py0 = yy; pz0 = '0;
      end
      sq_x = dx * dx;
      sq_z = dz * dz;
      n_c  = RW'(sq_x + sq_z);
   end

   // side words carried along the square root row
   logic signed [CW-1:0] lx_s [SQRT_N+1];
   logic signed [CW-1:0] ly_s [SQRT_N+1];
   logic signed [AW-1:0] lz_s [SQRT_N+1];
   logic signed [DW-1:0] dy_s [SQRT_N+1];
   logic                 zero_s [SQRT_N+1];
   logic                 bad_s  [SQRT_N+1];
   logic [RW-1:0]        n_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lx_s[0]   <= px0;
         ly_s[0]   <= py0;
         lz_s[0]   <= pz0;
         dy_s[0]   <= dy;
         zero_s[0] <= (dx == '0) && (dz == '0);
         bad_s[0]  <= bad_d_ff[DIV_N];
         n_ff      <= n_c;
         for (int k = 0; k < SQRT_N; k++) begin
            lx_s[k+1]   <= lx_s[k];
            ly_s[k+1]   <= ly_s[k];
            lz_s[k+1]   <= lz_s[k];
            dy_s[k+1]   <= dy_s[k];
            zero_s[k+1] <= zero_s[k];
            bad_s[k+1]  <= bad_s[k];
         end
      end
   end

   // square root row
   logic [RW-1:0] sq_n [SQRT_N+1];
   logic [RW-1:0] sq_r [SQRT_N+1];

   assign sq_n[0] = n_ff;
   assign sq_r[0] = '0;

   for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
      cemap_sqrt_cell #(.BIT_POS(2 * (SQRT_N - 1 - k))) u_sqrt (
         .clock(clock), .adv(adv),
         .num_in(sq_n[k]), .res_in(sq_r[k]),
         .num_out(sq_n[k+1]), .res_out(sq_r[k+1])
      );
   end

   // cordic rows: longitude and latitude side by side
   logic signed [CW-1:0] lon_x [CRD_N+1];
   logic signed [CW-1:0] lon_y [CRD_N+1];
   logic signed [AW-1:0] lon_z [CRD_N+1];
   logic signed [CW-1:0] lat_x [CRD_N+1];
   logic signed [CW-1:0] lat_y [CRD_N+1];
   logic signed [AW-1:0] lat_z [CRD_N+1];
   logic                 zero_c [CRD_N+1];
   logic                 bad_c  [CRD_N+1];

   assign lon_x[0]  = lx_s[SQRT_N];
   assign lon_y[0]  = ly_s[SQRT_N];
   assign lon_z[0]  = lz_s[SQRT_N];
   assign lat_x[0]  = signed'({{(CW-24){1'b0}}, sq_r[SQRT_N][15:0], 8'd0});
   assign lat_y[0]  = {{(CW-DW){dy_s[SQRT_N][DW-1]}}, dy_s[SQRT_N]} <<< 8;
   assign lat_z[0]  = '0;
   assign zero_c[0] = zero_s[SQRT_N];
   assign bad_c[0]  = bad_s[SQRT_N];

   for (genvar k = 0; k < CRD_N; k++) begin : g_cordic
      logic zero_ff, bad_ff;

      cemap_cordic_cell #(.IDX(k)) u_lon (
         .clock(clock), .adv(adv),
         .x_in(lon_x[k]), .y_in(lon_y[k]), .z_in(lon_z[k]),
         .x_out(lon_x[k+1]), .y_out(lon_y[k+1]), .z_out(lon_z[k+1])
      );
      cemap_cordic_cell #(.IDX(k)) u_lat (
         .clock(clock), .adv(adv),
         .x_in(lat_x[k]), .y_in(lat_y[k]), .z_in(lat_z[k]),
         .x_out(lat_x[k+1]), .y_out(lat_y[k+1]), .z_out(lat_z[k+1])
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff <= zero_c[k];
            bad_ff  <= bad_c[k];
         end
      end

      assign zero_c[k+1] = zero_ff;
      assign bad_c[k+1]  = bad_ff;
   end

   // scale stage: fraction of a turn times image extent
   logic signed [AW-1:0] frac_x, frac_y;
   logic [PXW-1:0]       prod_x_ff;
   logic [PYW-1:0]       prod_y_ff;
   logic                 neg_x_ff, neg_y_ff, bad_m_ff;

   always_comb begin
      frac_x = zero_c[CRD_N] ? cemap_pkg::HALF_TURN
                             : lon_z[CRD_N] + cemap_pkg::HALF_TURN;
      frac_y = (lat_z[CRD_N] <<< 1) + cemap_pkg::HALF_TURN;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff <= PXW'(frac_x[AW-2:0]) * PXW'(width_eff);
         prod_y_ff <= PYW'(frac_y[AW-2:0]) * PYW'(height_eff);
         neg_x_ff  <= frac_x[AW-1];
         neg_y_ff  <= frac_y[AW-1];
         bad_m_ff  <= bad_c[CRD_N];
      end
   end

   // clamp stage and response register
   logic [PXW-25:0]    pix_x;
   logic [PYW-25:0]    pix_y;
   logic [PXW-25:0]    lim_x;
   logic [PYW-25:0]    lim_y;
   cemap_pkg::rsp_type rsp_in;
   cemap_pkg::rsp_type rsp_ff;

   always_comb begin
      pix_x = prod_x_ff[PXW-1:24];
      pix_y = prod_y_ff[PYW-1:24];
      lim_x = (PXW-24)'(width_eff) - 1'b1;
      lim_y = (PYW-24)'(height_eff) - 1'b1;
      rsp_in.bad_request = bad_m_ff;
      if (bad_m_ff || neg_x_ff || (width_eff == '0))
         rsp_in.source_x = '0;
      else if (pix_x > lim_x)
         rsp_in.source_x = cemap_pkg::SRC_X_W'(lim_x);
      else
         rsp_in.source_x = cemap_pkg::SRC_X_W'(pix_x);
      if (bad_m_ff || neg_y_ff || (height_eff == '0))
         rsp_in.source_y = '0;
      else if (pix_y > lim_y)
         rsp_in.source_y = cemap_pkg::SRC_Y_W'(lim_y);
      else
         rsp_in.source_y = cemap_pkg::SRC_Y_W'(pix_y);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== dv/cemap_checker.sv =====
// cemap_checker: watches the request, response and register ports of the
// sample address block, predicts each response and compares. Uses cemap_pkg.
`timescale 1ns / 1ps

module cemap_checker
   import cemap_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_word,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending
);

   localparam int STAGES = 16;
   localparam longint QTR = 64'sd4194304;
   localparam longint HALF = 64'sd8388608;
   localparam longint UNIT = 64'sd32768;

   // arctangent steps in 2^-24 turn
   localparam longint ARC_STEP [24] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0};

   logic [SIZE_W-1:0]   cur_size;
   logic [WIDTH_W-1:0]  cur_width;
   logic [HEIGHT_W-1:0] cur_height;
   rsp_type             pixel_q[$];

   // atan2(ay, ax) by cordic vectoring
   function automatic longint turn_angle(longint ax, longint ay);
      longint x, y, z, nx;
      z = 0;
      if (ax < 0) begin
         if (ay >= 0) begin
            x = ay; y = -ax; z = QTR;
         end else begin
            x = -ay; y = ax; z = -QTR;
         end
      end else begin
         x = ax; y = ay;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ARC_STEP[i];
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ARC_STEP[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint floor_root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint pick_pixel(longint frac, longint ext);
      longint p;
      if (ext == 0 || frac < 0) return 0;
      p = (frac * ext) >>> 24;
      if (p > ext - 1) p = ext - 1;
      return p;
   endfunction

   function automatic rsp_type source_pixel(req_type r);
      rsp_type o;
      longint sz, w, h, u, v, dx, dy, dz, lon, lat, rad;
      sz = (cur_size > 4096) ? 4096 : cur_size;
      w = (cur_width > 8192) ? 8192 : cur_width;
      h = (cur_height > 4096) ? 4096 : cur_height;
      o = '0;
      if (r.face > FACE_NEG_Z || sz == 0 || r.texel_x >= sz || r.texel_y >= sz) begin
         o.bad_request = 1'b1;
         return o;
      end
      u = (((2 * longint'(r.texel_x) + 1) << 15) / sz) - UNIT;
      v = (((2 * longint'(r.texel_y) + 1) << 15) / sz) - UNIT;
      case (r.face)
         FACE_POS_X: begin dx = UNIT;  dy = -v;    dz = -u;    end
         FACE_NEG_X: begin dx = -UNIT; dy = -v;    dz = u;     end
         FACE_POS_Y: begin dx = u;     dy = UNIT;  dz = v;     end
         FACE_NEG_Y: begin dx = u;     dy = -UNIT; dz = -v;    end
         FACE_POS_Z: begin dx = u;     dy = -v;    dz = UNIT;  end
         default:    begin dx = -u;    dy = -v;    dz = -UNIT; end
      endcase
      // straight up or down: no horizontal heading
      lon = (dx == 0 && dz == 0) ? 0 : turn_angle(dx * 256, dz * 256);
      rad = floor_root(dx * dx + dz * dz);
      lat = turn_angle(rad * 256, dy * 256);
      o.source_x = SRC_X_W'(pick_pixel(lon + HALF, w));
      o.source_y = SRC_Y_W'(pick_pixel(2 * lat + HALF, h));
      return o;
   endfunction

   task automatic report(string what);
      if (errors < 30) $display("%0t mismatch: %s", $realtime, what);
      errors++;
   endtask

   initial errors = 0;
   assign pending = pixel_q.size();

   // register shadow, prediction on accept, comparison on response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cur_size <= CUBE_SIZE_RST;
         cur_width <= EQUI_WIDTH_RST;
         cur_height <= EQUI_HEIGHT_RST;
         pixel_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CUBE_SIZE:   cur_size <= csr_wdata[SIZE_W-1:0];
               CSR_EQUI_WIDTH:  cur_width <= csr_wdata[WIDTH_W-1:0];
               CSR_EQUI_HEIGHT: cur_height <= csr_wdata[HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) pixel_q.push_back(source_pixel(req_word));
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               report("word with nothing expected");
            end else begin
               want = pixel_q.pop_front();
               if (rsp_word.source_x !== want.source_x)
                  report($sformatf("source_x %0d want %0d", rsp_word.source_x,
                     want.source_x));
               if (rsp_word.source_y !== want.source_y)
                  report($sformatf("source_y %0d want %0d", rsp_word.source_y,
                     want.source_y));
               if (rsp_word.bad_request !== want.bad_request)
                  report($sformatf("bad_request %0b want %0b",
                     rsp_word.bad_request, want.bad_request));
            end
         end
      end
   end

endmodule

// ===== dv/tb_cubemap_to_equirect_sample_address_top.sv =====
// tb_cubemap_to_equirect_sample_address_top: drives requests, register writes
// and response back-pressure; verdict from cemap_checker. Uses cemap_pkg.
`timescale 1ns / 1ps

module tb_cubemap_to_equirect_sample_address_top;
   import cemap_pkg::*;

   localparam int LIMIT = 600000;
   localparam int DRAIN = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_word;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    errors, pending;
   int                    cycles = 0;
   int                    face_edge = 512;
   bit                    no_idle = 0;
   bit                    hold_off = 0;

   cubemap_to_equirect_sample_address_top dut (.*);

   cemap_checker chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_cubemap_to_equirect_sample_address_top NOT OK");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // response back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      int n;
      if (!reset) begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end else begin
            n = idle_len();
            if (n == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (n - 1) @(posedge clock);
            end
         end
      end
   end

   task automatic send(logic [FACE_W-1:0] f, int tx, int ty);
      int n;
      req_valid <= 1'b1;
      req_word <= '{face: f, texel_x: tx[TEXEL_W-1:0], texel_y: ty[TEXEL_W-1:0]};
      do @(posedge clock); while (!req_ready);
      n = idle_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // register write once the pipe is empty
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CUBE_SIZE) face_edge = (value & 16'h1fff) > 4096 ? 4096 : value & 16'h1fff;
   endtask

   task automatic setup(int sz, int w, int h);
      write_reg(CSR_CUBE_SIZE, sz);
      write_reg(CSR_EQUI_WIDTH, w);
      write_reg(CSR_EQUI_HEIGHT, h);
   endtask

   // mostly in-range texels on real faces, some rejects
   task automatic random_words(int count);
      int r, tx, ty, lim;
      logic [FACE_W-1:0] f;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         lim = (face_edge == 0) ? 0 : face_edge - 1;
         f = FACE_W'($urandom_range(5));
         tx = $urandom_range(lim);
         ty = $urandom_range(lim);
         if (r < 5) f = FACE_W'($urandom_range(7, 6));
         else if (r < 10) tx = $urandom_range(4095);
         else if (r < 15) ty = $urandom_range(4095);
         send(f, tx, ty);
      end
   endtask

   initial begin
      int c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, centers, every face, rejects, at reset settings
      for (int f = 0; f < 6; f++) begin
         send(FACE_W'(f), 0, 0);
         send(FACE_W'(f), 511, 511);
         send(FACE_W'(f), 255, 256);
      end
      send(3'd6, 0, 0);
      send(3'd7, 4095, 4095);
      send(FACE_POS_X, 512, 0);
      send(FACE_NEG_Z, 0, 4095);
      // odd face: exact pole at the center of the Y faces
      setup(7, 2048, 1024);
      send(FACE_POS_Y, 3, 3);
      send(FACE_NEG_Y, 3, 3);
      random_words(100);

      // smallest and largest settings
      setup(1, 1, 1);
      random_words(80);
      setup(4096, 8192, 4096);
      hold_off = 1;
      random_words(250);
      no_idle = 1;
      random_words(100);
      no_idle = 0;
      // values past the caps, then zero extents and zero face size
      setup(8191, 16383, 8191);
      random_words(150);
      setup(5, 0, 0);
      random_words(60);
      setup(0, 2048, 1024);
      random_words(40);
      // assorted settings
      for (int p = 0; p < 5; p++) begin
         setup($urandom_range(4096, 1), $urandom_range(8192, 1), $urandom_range(4096, 1));
         random_words(90);
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("tb_cubemap_to_equirect_sample_address_top OK");
      else
         $display("tb_cubemap_to_equirect_sample_address_top NOT OK");
      $finish;
   end

endmodule
